### rtl/rlpc_pkg.sv
package rlpc_pkg;

   // Modes of an input word
   localparam logic [1:0] MODE_ROM_WRITE  = 2'd0;
   localparam logic [1:0] MODE_DESC_WRITE = 2'd1;
   localparam logic [1:0] MODE_QUERY      = 2'd2;

   // Screen geometry; the internal position runs 32 ahead of the visible column
   localparam int SCREEN_WIDTH = 320;
   localparam int POS_OFFSET   = 32;
   localparam int VIS_HI       = SCREEN_WIDTH + POS_OFFSET;

   // Line geometry
   localparam int X_ORIGIN     = 16 + 512 - 6;
   localparam int ROAD_CENTER  = 'h200;
   localparam int EDGE_WIDTH   = 32;
   localparam int LINE_BASE    = 'h400;
   localparam int BASE_BITS    = 21;

   // Palette offsets inside a bank
   localparam logic [7:0] OFS_ROAD       = 8'd0;
   localparam logic [7:0] OFS_EDGE       = 8'd4;
   localparam logic [7:0] OFS_LEFT_GRASS = 8'd8;
   localparam logic [7:0] OFS_RIGHT_GRASS = 8'd12;

   // Descriptor words of one layer
   localparam int DESC_WORDS  = 4;
   localparam int DESC_START  = 0;
   localparam int DESC_END    = 1;
   localparam int DESC_XOFS   = 2;
   localparam int DESC_LINE   = 3;
   localparam int NUM_LAYERS  = 2;
   localparam int DESC_SLOTS  = NUM_LAYERS * DESC_WORDS;

   // Register file
   localparam int         CSR_ADDR_W        = 3;
   localparam logic [0:0] REG_LAYER0_ENABLE = 1'b0;

   typedef struct packed {
      logic [1:0]  mode;
      logic [20:0] target_address;
      logic [15:0] write_value;
      logic [8:0]  column;
   } req_word_type;

   typedef struct packed {
      logic       pixel_valid;
      logic [7:0] color_index;
   } rsp_word_type;

   // Regions of one layer that the queried position falls in
   typedef struct packed {
      logic       left_grass;
      logic       right_grass;
      logic       left_edge;
      logic       right_edge;
      logic       middle;
      logic [3:0] bank;
   } layer_hit_type;

endpackage

### rtl/road_layer_pixel_composer.sv
// Channel  Direction  Word            Handshake
// req      in         req_word_type   req_valid / req_stall
// rsp      out        rsp_word_type   rsp_valid / rsp_stall
// csr      in         APB write/read  psel, penable, pwrite / pready (always 1)
//
// One word is taken every cycle while req_stall is low. A query reads both layers'
// graphics bytes when taken (two memory read ports); its result reaches rsp
// via the compose and output registers. ROM and descriptor writes give no result.
// Synchronous reset clears the pipeline valids and sets layer0_enable; graphics
// memory and descriptors keep their contents and need writing before use.
// rsp_stall holds the output register, then the compose stage, then raises req_stall.
module road_layer_pixel_composer
   import rlpc_pkg::*;
#(
   parameter int ROM_ADDRESS_BITS = 21
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int AW    = ROM_ADDRESS_BITS;
   localparam int SUM_W = (AW > BASE_BITS) ? AW : BASE_BITS;

   // Graphics memory and its registered read ports
   logic [7:0]           rom_mem [2**AW];
   logic [7:0]           rom_rd_ff [NUM_LAYERS];
   logic [AW-1:0]        rd_addr [NUM_LAYERS];
   logic                 rd_en;
   logic                 rom_we;
   logic [AW-1:0]        wr_addr;

   logic [15:0]          desc_ff [DESC_SLOTS];
   logic                 layer0_enable_ff;

   logic                 accept;
   logic                 s1_load;
   logic                 out_free;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   layer_hit_type        hit_in [NUM_LAYERS];
   layer_hit_type        hit_ff [NUM_LAYERS];

   logic                 rsp_valid_ff;
   rsp_word_type         rsp_word_ff;
   rsp_word_type         rsp_word_in;

   logic signed [12:0]   pos;
   logic                 visible;
   logic signed [12:0]   x_s [NUM_LAYERS];
   logic signed [12:0]   aa_s [NUM_LAYERS];
   logic signed [12:0]   bb_s [NUM_LAYERS];
   logic signed [12:0]   rx_s [NUM_LAYERS];
   logic signed [12:0]   ofs_s [NUM_LAYERS];
   logic [BASE_BITS-1:0] base_v [NUM_LAYERS];
   logic [SUM_W-1:0]     addr_sum [NUM_LAYERS];

   logic                 csr_write;

   // ---------------- handshake ----------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || out_free;
   assign req_stall = !s1_load;
   assign accept    = req_valid && s1_load;

   assign rd_en   = accept && (req_word.mode == MODE_QUERY);
   assign rom_we  = accept && (req_word.mode == MODE_ROM_WRITE);
   assign wr_addr = AW'(req_word.target_address);

   // ---------------- configuration ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1:2] == REG_LAYER0_ENABLE) begin
         prdata = {31'd0, layer0_enable_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer0_enable_ff <= 1'b1;
      end else if (csr_write && (paddr[CSR_ADDR_W-1:2] == REG_LAYER0_ENABLE)) begin
         layer0_enable_ff <= pwdata[0];
      end
   end

   // ---------------- descriptors ----------------
   always_ff @(posedge clock) begin
      if (accept && (req_word.mode == MODE_DESC_WRITE)
          && (req_word.target_address[20:3] == '0)) begin
         desc_ff[req_word.target_address[2:0]] <= req_word.write_value;
      end
   end

   // ---------------- per-layer decode at accept ----------------
   always_comb begin
      pos     = $signed({4'd0, req_word.column}) + 13'(POS_OFFSET);
      visible = pos < 13'(VIS_HI);
      for (int l = 0; l < NUM_LAYERS; l++) begin
         logic [15:0] w0;
         logic [15:0] w1;
         logic [15:0] w2;
         logic [15:0] w3;
         logic        on;
         logic        line_nz;
         w0 = desc_ff[l*DESC_WORDS + DESC_START];
         w1 = desc_ff[l*DESC_WORDS + DESC_END];
         w2 = desc_ff[l*DESC_WORDS + DESC_XOFS];
         w3 = desc_ff[l*DESC_WORDS + DESC_LINE];
         on      = ((l == 0) ? layer0_enable_ff : 1'b1) && visible;
         line_nz = (w3[9:0] != '0);

         x_s[l]  = 13'(X_ORIGIN) - $signed({2'd0, w2[10:0]});
         aa_s[l] = 13'(ROAD_CENTER) - $signed({4'd0, w0[8:0]});
         bb_s[l] = 13'(ROAD_CENTER) + $signed({4'd0, w1[8:0]});
         rx_s[l] = pos - x_s[l];

         hit_in[l].bank        = w3[15:12];
         hit_in[l].left_grass  = on && w0[15] && (pos < x_s[l] + aa_s[l]);
         hit_in[l].right_grass = on && w1[15] && (pos >= x_s[l] + bb_s[l]);
         hit_in[l].left_edge   = on && line_nz && (rx_s[l] >= aa_s[l] - 13'(EDGE_WIDTH))
                                 && (rx_s[l] < aa_s[l]);
         hit_in[l].right_edge  = on && line_nz && (rx_s[l] >= bb_s[l])
                                 && (rx_s[l] < bb_s[l] + 13'(EDGE_WIDTH));
         hit_in[l].middle      = on && line_nz && (rx_s[l] >= aa_s[l])
                                 && (rx_s[l] < bb_s[l]);

         // edge strips read from the 512 bytes below the road part of the line
         if (rx_s[l] < aa_s[l]) begin
            ofs_s[l] = rx_s[l] - aa_s[l] - 13'(ROAD_CENTER);
         end else if (rx_s[l] >= bb_s[l]) begin
            ofs_s[l] = rx_s[l] - bb_s[l] - 13'(ROAD_CENTER);
         end else begin
            ofs_s[l] = rx_s[l];
         end

         base_v[l]   = {w3[9:0], 11'(LINE_BASE)};
         addr_sum[l] = SUM_W'(base_v[l]) + SUM_W'(ofs_s[l]);
         rd_addr[l]  = AW'(addr_sum[l]);
      end
   end

   // ---------------- graphics memory ----------------
   always_ff @(posedge clock) begin
      if (rom_we) begin
         rom_mem[wr_addr] <= req_word.write_value[7:0];
      end
      if (rd_en) begin
         for (int l = 0; l < NUM_LAYERS; l++) begin
            rom_rd_ff[l] <= rom_mem[rd_addr[l]];
         end
      end
   end

   // ---------------- compose stage ----------------
   assign s1_valid_in = rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         hit_ff <= hit_in;
      end
   end

   // Later stages overwrite earlier ones; layer 1 overwrites layer 0 within a stage
   always_comb begin
      logic [7:0] bank16;
      rsp_word_in = '0;
      for (int l = 0; l < NUM_LAYERS; l++) begin
         bank16 = {hit_ff[l].bank, 4'd0};
         if (hit_ff[l].left_grass) begin
            rsp_word_in = '{pixel_valid: 1'b1, color_index: bank16 + OFS_LEFT_GRASS};
         end
      end
      for (int l = 0; l < NUM_LAYERS; l++) begin
         bank16 = {hit_ff[l].bank, 4'd0};
         if (hit_ff[l].right_grass) begin
            rsp_word_in = '{pixel_valid: 1'b1, color_index: bank16 + OFS_RIGHT_GRASS};
         end
      end
      for (int l = 0; l < NUM_LAYERS; l++) begin
         bank16 = {hit_ff[l].bank, 4'd0};
         if (hit_ff[l].left_edge && (rom_rd_ff[l] != '0)) begin
            rsp_word_in = '{pixel_valid: 1'b1,
                            color_index: bank16 + OFS_EDGE + rom_rd_ff[l]};
         end
      end
      for (int l = 0; l < NUM_LAYERS; l++) begin
         bank16 = {hit_ff[l].bank, 4'd0};
         if (hit_ff[l].right_edge && (rom_rd_ff[l] != '0)) begin
            rsp_word_in = '{pixel_valid: 1'b1,
                            color_index: bank16 + OFS_EDGE + rom_rd_ff[l]};
         end
      end
      for (int l = 0; l < NUM_LAYERS; l++) begin
         bank16 = {hit_ff[l].bank, 4'd0};
         if (hit_ff[l].middle) begin
            rsp_word_in = '{pixel_valid: 1'b1,
                            color_index: bank16 + OFS_ROAD + rom_rd_ff[l]};
         end
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_query_enters_stage: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_word.mode == MODE_QUERY)) |=> s1_valid_ff)
      else $error("accepted query did not reach the compose stage");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_word.mode != MODE_QUERY)) |=> !s1_valid_ff)
      else $error("non-query word produced a compose entry");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input taken while compose stage is blocked");

   a_blank_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.pixel_valid) |-> (rsp_word_ff.color_index == '0))
      else $error("background pixel carries a color index");
`endif

endmodule

### dv/tb_road_layer_pixel_composer.sv
module tb_road_layer_pixel_composer
   import rlpc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] L0EN_ADDR = CSR_ADDR_W'(4 * REG_LAYER0_ENABLE);
   localparam int EDGE_ROM_SHIFT = 512;
   localparam int ROM_TOP = (1 << BASE_BITS) - 1;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum int {
      PART_NONE, PART_LEFT_EDGE, PART_RIGHT_EDGE, PART_MIDDLE
   } road_part_type;

   typedef enum int {
      STAGE_LEFT_GRASS, STAGE_RIGHT_GRASS, STAGE_LEFT_EDGE, STAGE_RIGHT_EDGE, STAGE_MIDDLE,
      STAGE_COUNT
   } draw_stage_type;

   typedef struct {
      bit            left_grass;
      bit            right_grass;
      logic [3:0]    bank;
      road_part_type part;
      logic [20:0]   addr;
   } layer_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // Words waiting to be sent, results owed by the block
   req_word_type word_q[$];
   rsp_word_type pixel_due_q[$];

   // Predicted block state, updated as words are taken
   logic [7:0]  pred_rom [logic [20:0]];
   logic [15:0] pred_desc [DESC_SLOTS];
   bit          pred_l0_on = 1'b1;

   // Stimulus-side view: what has been queued so far
   bit          rom_queued [logic [20:0]];
   logic [15:0] plan_desc [DESC_SLOTS];

   bit           idle_on = 1'b1;
   bit           req_fire = 1'b0;
   int           req_gap = 0;
   int           rsp_hold = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   rsp_word_type pixel_want;

   road_layer_pixel_composer dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_word,
      .rsp_valid, .rsp_stall, .rsp_word,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Decode one layer's descriptor words at internal position p
   function automatic layer_view_type view_layer(input logic [15:0] w_start, w_end, w_xofs,
                                                 w_line, input int p);
      layer_view_type v;
      int x, aa, bb, rx, base, a;
      x    = X_ORIGIN - int'(w_xofs[10:0]);
      aa   = ROAD_CENTER - int'(w_start[8:0]);
      bb   = ROAD_CENTER + int'(w_end[8:0]);
      base = ((int'(w_line[9:0]) << 11) + LINE_BASE) & ROM_TOP;
      rx   = p - x;
      a    = 0;
      v.bank        = w_line[15:12];
      v.left_grass  = w_start[15] && (p < x + aa);
      v.right_grass = w_end[15] && (p >= x + bb);
      v.part        = PART_NONE;
      if (w_line[9:0] != 10'd0) begin
         if (rx >= aa - EDGE_WIDTH && rx < aa) begin
            v.part = PART_LEFT_EDGE;
            a = base + rx - aa - EDGE_ROM_SHIFT;
         end else if (rx >= bb && rx < bb + EDGE_WIDTH) begin
            v.part = PART_RIGHT_EDGE;
            a = base + rx - bb - EDGE_ROM_SHIFT;
         end else if (rx >= aa && rx < bb) begin
            v.part = PART_MIDDLE;
            a = base + rx;
         end
      end
      // wrap to the ROM size
      v.addr = a[20:0];
      return v;
   endfunction

   function automatic void predict_word(input req_word_type w);
      rsp_word_type   px;
      layer_view_type v;
      logic [7:0]     rom_byte;
      logic [7:0]     bank_base;
      int             p;
      case (w.mode)
         MODE_ROM_WRITE: pred_rom[w.target_address] = w.write_value[7:0];
         MODE_DESC_WRITE: begin
            if (w.target_address < DESC_SLOTS)
               pred_desc[w.target_address[2:0]] = w.write_value;
         end
         MODE_QUERY: begin
            px = '0;
            p = int'(w.column) + POS_OFFSET;
            if (p < VIS_HI) begin
               for (int st = 0; st < STAGE_COUNT; st++) begin
                  for (int ly = 0; ly < NUM_LAYERS; ly++) begin
                     if (ly == 0 && !pred_l0_on)
                        continue;
                     v = view_layer(pred_desc[DESC_WORDS * ly + DESC_START],
                                    pred_desc[DESC_WORDS * ly + DESC_END],
                                    pred_desc[DESC_WORDS * ly + DESC_XOFS],
                                    pred_desc[DESC_WORDS * ly + DESC_LINE], p);
                     rom_byte = (v.part != PART_NONE && pred_rom.exists(v.addr)) ?
                                pred_rom[v.addr] : 8'h00;
                     bank_base = {v.bank, 4'h0};
                     case (draw_stage_type'(st))
                        STAGE_LEFT_GRASS: begin
                           if (v.left_grass)
                              px = '{1'b1, bank_base + OFS_LEFT_GRASS};
                        end
                        STAGE_RIGHT_GRASS: begin
                           if (v.right_grass)
                              px = '{1'b1, bank_base + OFS_RIGHT_GRASS};
                        end
                        STAGE_LEFT_EDGE: begin
                           if (v.part == PART_LEFT_EDGE && rom_byte != 8'h00)
                              px = '{1'b1, bank_base + OFS_EDGE + rom_byte};
                        end
                        STAGE_RIGHT_EDGE: begin
                           if (v.part == PART_RIGHT_EDGE && rom_byte != 8'h00)
                              px = '{1'b1, bank_base + OFS_EDGE + rom_byte};
                        end
                        default: begin
                           // road middle draws even a zero byte
                           if (v.part == PART_MIDDLE)
                              px = '{1'b1, bank_base + OFS_ROAD + rom_byte};
                        end
                     endcase
                  end
               end
            end
            pixel_due_q.push_back(px);
         end
         default: ;
      endcase
   endfunction

   // Take words and check results at the rising edge
   always @(posedge clock) begin
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire)
         predict_word(req_word);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_due_q.size() == 0) begin
            report_mismatch("result word with none owed", 32'(rsp_word), '0);
         end else begin
            pixel_want = pixel_due_q.pop_front();
            if (rsp_word.pixel_valid !== pixel_want.pixel_valid)
               report_mismatch("pixel_valid", 32'(rsp_word.pixel_valid),
                               32'(pixel_want.pixel_valid));
            if (rsp_word.color_index !== pixel_want.color_index)
               report_mismatch("color_index", 32'(rsp_word.color_index),
                               32'(pixel_want.color_index));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Request driver: advance on acceptance, insert idle bursts
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
            req_gap = $urandom_range(1, 5);
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (word_q.size() != 0) begin
            req_word <= word_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure in bursts
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else if (!reset && idle_on && $urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void queue_word(input logic [1:0] mode, input logic [20:0] addr,
                                      input logic [15:0] value, input logic [8:0] col);
      req_word_type w;
      w.mode           = mode;
      w.target_address = addr;
      w.write_value    = value;
      w.column         = col;
      word_q.push_back(w);
      if (mode == MODE_ROM_WRITE)
         rom_queued[addr] = 1'b1;
      else if (mode == MODE_DESC_WRITE && addr < DESC_SLOTS)
         plan_desc[addr[2:0]] = value;
   endfunction

   function automatic logic [15:0] rom_fill(input bit blank);
      logic [7:0] hi;
      hi = 8'($urandom);
      if (blank || $urandom_range(0, 4) == 0)
         return {hi, 8'h00};
      return {hi, 8'($urandom_range(1, 255))};
   endfunction

   // Queue a query, first filling any graphics byte it would read
   function automatic int queue_query(input logic [8:0] col, input bit blank);
      layer_view_type v;
      int n;
      n = 1;
      for (int ly = 0; ly < NUM_LAYERS; ly++) begin
         v = view_layer(plan_desc[DESC_WORDS * ly + DESC_START],
                        plan_desc[DESC_WORDS * ly + DESC_END],
                        plan_desc[DESC_WORDS * ly + DESC_XOFS],
                        plan_desc[DESC_WORDS * ly + DESC_LINE], int'(col) + POS_OFFSET);
         if (v.part != PART_NONE && !rom_queued.exists(v.addr)) begin
            queue_word(MODE_ROM_WRITE, v.addr, rom_fill(blank), 9'($urandom));
            n++;
         end
      end
      queue_word(MODE_QUERY, 21'($urandom), 16'($urandom), col);
      return n;
   endfunction

   function automatic logic [8:0] pick_column();
      case ($urandom_range(0, 9))
         0: return 9'($urandom_range(SCREEN_WIDTH, 511));
         1: return $urandom_range(0, 1) ? 9'd0 : 9'(SCREEN_WIDTH - 1);
         default: return 9'($urandom_range(0, SCREEN_WIDTH - 1));
      endcase
   endfunction

   // Well-formed descriptor word; the x offset keeps the road on screen most of the time
   function automatic logic [15:0] desc_word(input int slot);
      int word_idx, layer_base, aa, bb, xofs;
      logic [15:0] w;
      word_idx   = slot % DESC_WORDS;
      layer_base = slot - word_idx;
      w = 16'($urandom);
      case (word_idx)
         DESC_XOFS: begin
            if ($urandom_range(0, 4) != 0) begin
               aa = ROAD_CENTER - int'(plan_desc[layer_base + DESC_START][8:0]);
               bb = ROAD_CENTER + int'(plan_desc[layer_base + DESC_END][8:0]);
               xofs = X_ORIGIN - $urandom_range(POS_OFFSET, VIS_HI - 1) + (aa + bb) / 2;
               w[10:0] = 11'(xofs);
            end
         end
         DESC_LINE: begin
            if ($urandom_range(0, 7) == 0)
               w[9:0] = 10'd0;
            else if (w[9:0] == 10'd0)
               w[9:0] = 10'd1;
         end
         default: ;
      endcase
      return w;
   endfunction

   function automatic void queue_directed();
      int n;
      // layer 0: grass both sides, road middle over most of the screen, top line
      queue_word(MODE_DESC_WRITE, 21'(DESC_START), 16'h8070, 9'd0);
      queue_word(MODE_DESC_WRITE, 21'(DESC_END), 16'h8070, 9'd0);
      queue_word(MODE_DESC_WRITE, 21'(DESC_XOFS), 16'h034A, 9'd0);
      queue_word(MODE_DESC_WRITE, 21'(DESC_LINE), 16'h33FF, 9'd0);
      // layer 1: narrow road in the center, highest bank
      queue_word(MODE_DESC_WRITE, 21'(DESC_WORDS + DESC_START), 16'h0020, 9'h1FF);
      queue_word(MODE_DESC_WRITE, 21'(DESC_WORDS + DESC_END), 16'h0020, 9'h1FF);
      queue_word(MODE_DESC_WRITE, 21'(DESC_WORDS + DESC_XOFS), 16'hF34A, 9'h1FF);
      queue_word(MODE_DESC_WRITE, 21'(DESC_WORDS + DESC_LINE), 16'hFC05, 9'h1FF);
      queue_word(MODE_ROM_WRITE, 21'h000000, 16'h00AB, 9'd0);
      queue_word(MODE_ROM_WRITE, 21'h1FFFFF, 16'hFFFF, 9'h1FF);
      // ignored words: slot past the table, unused mode
      queue_word(MODE_DESC_WRITE, 21'(DESC_SLOTS), 16'hFFFF, 9'd0);
      queue_word(MODE_DESC_WRITE, 21'h1FFFFF, 16'hFFFF, 9'h1FF);
      queue_word(MODE_UNUSED, 21'h1FFFFF, 16'hFFFF, 9'h1FF);
      n = queue_query(9'd0, 1'b0);
      n = queue_query(9'd20, 1'b1);
      n = queue_query(9'd30, 1'b0);
      n = queue_query(9'd47, 1'b0);
      n = queue_query(9'd48, 1'b0);
      n = queue_query(9'd150, 1'b0);
      n = queue_query(9'd271, 1'b0);
      n = queue_query(9'd272, 1'b0);
      n = queue_query(9'd280, 1'b1);
      n = queue_query(9'd304, 1'b0);
      n = queue_query(9'(SCREEN_WIDTH - 1), 1'b0);
      n = queue_query(9'(SCREEN_WIDTH), 1'b0);
      n = queue_query(9'h1FF, 1'b0);
   endfunction

   function automatic void queue_random(input int target);
      int made;
      made = 0;
      while (made < target) begin
         for (int s = 0; s < DESC_SLOTS; s++)
            queue_word(MODE_DESC_WRITE, 21'(s), desc_word(s), 9'($urandom));
         made += DESC_SLOTS;
         repeat ($urandom_range(10, 40)) begin
            case ($urandom_range(0, 19))
               0: queue_word(MODE_UNUSED, 21'($urandom), 16'($urandom), 9'($urandom));
               1: queue_word(MODE_DESC_WRITE, 21'($urandom_range(DESC_SLOTS, ROM_TOP)),
                             16'($urandom), 9'($urandom));
               2: begin
                  queue_word(MODE_ROM_WRITE, 21'($urandom), 16'($urandom), 9'($urandom));
                  made++;
               end
               3: begin
                  int slot;
                  slot = $urandom_range(0, DESC_SLOTS - 1);
                  queue_word(MODE_DESC_WRITE, 21'(slot), desc_word(slot), 9'($urandom));
                  made++;
               end
               default: made += queue_query(pick_column(), 1'b0);
            endcase
         end
      end
   endfunction

   // Hold until every word is taken and every result is back, then let the pipe empty
   task automatic drain();
      while (word_q.size() != 0 || req_valid || pixel_due_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= L0EN_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      pred_l0_on = value[0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= L0EN_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[0] !== pred_l0_on)
         report_mismatch("layer0_enable readback", 32'(prdata[0]), 32'(pred_l0_on));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_read_check();

      queue_directed();
      drain();

      csr_write(32'd0);
      csr_read_check();
      queue_random(250);
      drain();

      csr_write(32'd1);
      csr_read_check();
      queue_random(250);
      drain();

      // closing stretch at full rate
      idle_on = 1'b0;
      queue_random(150);
      drain();

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
